// ----- hdl/hcd_pkg.sv -----
// Shared types, command codes and character constants for the chunked body decoder.
package hcd_pkg;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int unsigned LEN_W = 32;
  localparam logic [LEN_W-1:0] LEN_UNBOUNDED = '1;

  localparam logic [3:0] MAX_DIGITS = 4'd8;

  // Register indexes on the configuration port.
  localparam logic REG_CHUNKED_MODE   = 1'b0;
  localparam logic REG_CONTENT_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_done;
    logic       protocol_error;
    logic       not_consumed;
  } out_item_t;

  typedef struct packed {
    logic             chunked_mode;
    logic [LEN_W-1:0] content_length;
  } cfg_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- hdl/hcd_parser.sv -----
// Body framing state and the per-byte decode step of the chunked body decoder.
module hcd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  hcd_pkg::in_item_t  item,
  input  hcd_pkg::cfg_t      cfg,
  output hcd_pkg::out_item_t result
);

  typedef enum logic [2:0] {
    PH_ENDED,
    PH_IDENT,
    PH_SIZE,
    PH_EXT,
    PH_DELIM,
    PH_DELIMLF,
    PH_DATA,
    PH_ERROR
  } phase_t;

  phase_t                     phase, phase_next;
  logic [hcd_pkg::LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [hcd_pkg::LEN_W-1:0]  size_accum, size_accum_next;
  logic [3:0]                 digit_count, digit_count_next;
  logic                       unbounded_body, unbounded_body_next;

  hcd_pkg::hex_digit_t        hex;
  logic                       last_byte;

  assign hex       = hcd_pkg::hex_decode(item.data_byte);
  assign last_byte = (bytes_left == hcd_pkg::LEN_W'(1));

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    size_accum_next     = size_accum;
    digit_count_next    = digit_count;
    unbounded_body_next = unbounded_body;
    result              = '0;

    case (item.cmd)
      hcd_pkg::CMD_START: begin
        bytes_left_next     = '0;
        size_accum_next     = '0;
        digit_count_next    = '0;
        unbounded_body_next = 1'b0;
        if (cfg.chunked_mode) begin
          phase_next = PH_SIZE;
        end else if (cfg.content_length == hcd_pkg::LEN_UNBOUNDED) begin
          unbounded_body_next = 1'b1;
          phase_next          = PH_IDENT;
        end else if (cfg.content_length == '0) begin
          phase_next       = PH_ENDED;
          result.body_done = 1'b1;
        end else begin
          bytes_left_next = cfg.content_length;
          phase_next      = PH_IDENT;
        end
      end

      hcd_pkg::CMD_END: begin
        if (phase == PH_IDENT && unbounded_body) begin
          phase_next       = PH_ENDED;
          result.body_done = 1'b1;
        end else if (phase != PH_ENDED && phase != PH_ERROR) begin
          phase_next            = PH_ERROR;
          result.protocol_error = 1'b1;
        end
      end

      hcd_pkg::CMD_DATA: begin
        case (phase)
          PH_IDENT: begin
            result.body_valid = 1'b1;
            result.body_byte  = item.data_byte;
            if (!unbounded_body) begin
              bytes_left_next = bytes_left - hcd_pkg::LEN_W'(1);
              if (last_byte) begin
                phase_next       = PH_ENDED;
                result.body_done = 1'b1;
              end
            end
          end

          PH_SIZE, PH_EXT: begin
            if (phase == PH_SIZE && hex.is_hex) begin
              if (digit_count >= hcd_pkg::MAX_DIGITS) begin
                phase_next            = PH_ERROR;
                result.protocol_error = 1'b1;
              end else begin
                size_accum_next  = {size_accum[hcd_pkg::LEN_W-5:0], hex.value};
                digit_count_next = digit_count + 4'd1;
              end
            end else if (item.data_byte == hcd_pkg::CHAR_LF) begin
              // Size line complete: zero size closes the body.
              if (size_accum == '0) begin
                phase_next       = PH_ENDED;
                result.body_done = 1'b1;
              end else begin
                bytes_left_next = size_accum;
                phase_next      = PH_DATA;
              end
            end else if (phase == PH_SIZE) begin
              phase_next = PH_EXT;
            end
          end

          PH_DELIM: begin
            if (item.data_byte == hcd_pkg::CHAR_CR) begin
              phase_next = PH_DELIMLF;
            end else if (item.data_byte == hcd_pkg::CHAR_LF) begin
              size_accum_next  = '0;
              digit_count_next = '0;
              phase_next       = PH_SIZE;
            end else begin
              phase_next            = PH_ERROR;
              result.protocol_error = 1'b1;
            end
          end

          PH_DELIMLF: begin
            if (item.data_byte == hcd_pkg::CHAR_LF) begin
              size_accum_next  = '0;
              digit_count_next = '0;
              phase_next       = PH_SIZE;
            end else begin
              phase_next            = PH_ERROR;
              result.protocol_error = 1'b1;
            end
          end

          PH_DATA: begin
            result.body_valid = 1'b1;
            result.body_byte  = item.data_byte;
            bytes_left_next   = bytes_left - hcd_pkg::LEN_W'(1);
            if (last_byte) begin
              phase_next = PH_DELIM;
            end
          end

          default: begin
            // No body open: hand the byte back.
            result.not_consumed = 1'b1;
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ENDED;
      bytes_left     <= '0;
      size_accum     <= '0;
      digit_count    <= '0;
      unbounded_body <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      size_accum     <= size_accum_next;
      digit_count    <= digit_count_next;
      unbounded_body <= unbounded_body_next;
    end
  end

endmodule

// ----- hdl/http_body_chunked_decoder.sv -----
// HTTP message body decoder: identity length or chunked transfer coding, top level.
//
// One transaction on the stream side carries a command (data byte, end of input, or start
// of a new body) and a byte; every accepted transaction yields exactly one result
// transaction, carrying the body byte if any plus done, error and not-consumed flags.
// Sustained rate is one transaction per clock while the result side is not stalled: the
// framing state machine updates in the same edge that accepts the transaction, and the
// result lands in an output register backed by a one-entry skid register. The stream side
// is stalled only while the skid entry is occupied, so a result in the output register
// alone never blocks the next byte. The two configuration registers (chunked_mode at byte
// address 0, content_length at byte address 4) are written over the APB-style port and are
// sampled when a start command arrives; write them only while no transaction is in flight.
module http_body_chunked_decoder (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       stream_valid,
  output logic                       stream_stall,
  input  hcd_pkg::in_item_t          stream_item,

  output logic                       result_valid,
  input  logic                       result_stall,
  output hcd_pkg::out_item_t         result_item,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  hcd_pkg::cfg_t      cfg;
  hcd_pkg::out_item_t step_result;
  hcd_pkg::out_item_t skid_item;
  logic               skid_valid;
  logic               accept;
  logic               out_free;
  logic               load_out_from_skid;
  logic               load_out_from_step;
  logic               load_skid;
  logic               reg_sel;

  // Configuration port: register index is the word address bit.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunked_mode   <= 1'b0;
      cfg.content_length <= hcd_pkg::LEN_UNBOUNDED;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        hcd_pkg::REG_CHUNKED_MODE:   cfg.chunked_mode   <= pwdata[0];
        hcd_pkg::REG_CONTENT_LENGTH: cfg.content_length <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hcd_pkg::REG_CHUNKED_MODE:   prdata = {31'd0, cfg.chunked_mode};
      hcd_pkg::REG_CONTENT_LENGTH: prdata = cfg.content_length;
      default:                     prdata = '0;
    endcase
  end

  // Stall the stream only while the skid entry holds a result.
  assign stream_stall = skid_valid;
  assign accept       = stream_valid && !stream_stall;

  hcd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .item   (stream_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // Output slot frees when empty or when its transaction is taken this cycle.
  assign out_free           = !result_valid || !result_stall;
  assign load_out_from_skid = out_free && skid_valid;
  assign load_out_from_step = out_free && !skid_valid && accept;
  // Park a fresh result in the skid entry when the output slot is held.
  assign load_skid          = !out_free && accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= skid_valid || accept;
        skid_valid   <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_from_skid) begin
      result_item <= skid_item;
    end else if (load_out_from_step) begin
      result_item <= step_result;
    end
    if (load_skid) begin
      skid_item <= step_result;
    end
  end

endmodule

// ----- hdl/hcd_checker.sv -----
// Port-level assertions for the chunked body decoder, bound to the top level.
module hcd_checker (
  input logic               clk,
  input logic               rst,
  input logic               stream_valid,
  input logic               stream_stall,
  input logic               result_valid,
  input logic               result_stall,
  input hcd_pkg::out_item_t result_item
);

  // Every accepted transaction leaves a result pending on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    stream_valid && !stream_stall |=> result_valid)
    else $error("accepted transaction produced no pending result");

  // The stream side stalls only while a result is held at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    stream_stall |-> result_valid)
    else $error("stream stalled with no result pending");

  // A held result stays put until taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed or dropped");

  // Reset empties both the output register and the skid entry.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !stream_stall)
    else $error("result or stall survived reset");

endmodule

bind http_body_chunked_decoder hcd_checker u_hcd_checker (
  .clk         (clk),
  .rst         (rst),
  .stream_valid(stream_valid),
  .stream_stall(stream_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_item (result_item)
);
